@@ hdl/efs_pkg.sv @@
// Package for the escaped field splitter: shared types, constants and sizes.
// Used by the queue, front, back and top modules; not by the RAM or the channel interfaces.
package efs_pkg;

    // Depth of the trailing whitespace buffer and derived widths.
    localparam int PENDING_DEPTH = 16;
    localparam int PEND_AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int PEND_CW = $clog2(PENDING_DEPTH + 1);

    // Depth of the command queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

    // Character codes.
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB = 8'h09;

    // Configuration register indexes (byte address / 4).
    localparam int CFG_AW = 5;
    localparam logic [2:0] REG_SEPARATOR = 3'd0;
    localparam logic [2:0] REG_SEP_IS_WS = 3'd1;
    localparam logic [2:0] REG_MAX_FIELDS = 3'd2;
    localparam logic [2:0] REG_GROUP_SEPS = 3'd3;
    localparam logic [2:0] REG_TRIM_FIELDS = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [7:0] SEPARATOR_RESET = 8'd44;

    typedef struct packed {
        logic [7:0]  separator;
        logic        sep_is_whitespace;
        logic [15:0] max_fields;
        logic        group_separators;
        logic        trim_fields;
    } t_cfg;

    // Work handed from the front part to the back part.
    typedef enum logic [1:0] {
        OP_CHAR,
        OP_CLOSE,
        OP_FLUSH
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic [7:0]           char_byte;
        logic [15:0]          field_index;
        logic                 overflow;
        logic [PEND_CW-1:0]   pend_count;
    } t_cmd;

    // Write port of the pending whitespace buffer.
    typedef struct packed {
        logic               we;
        logic [PEND_AW-1:0] addr;
        logic [7:0]         data;
    } t_ram_wr;

    // Back part sequencer states.
    typedef enum logic {
        BK_IDLE,
        BK_FLUSH
    } t_bk_state;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c == CHAR_TAB);
    endfunction

endpackage

@@ hdl/efs_in_if.sv @@
// Input channel of the field splitter: one string byte or an end-of-string mark.
// Depends on nothing but the handshake convention valid/ready.
interface efs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_string;

    modport source (output valid, output in_byte, output end_of_string, input ready);
    modport sink (input valid, input in_byte, input end_of_string, output ready);
endinterface

@@ hdl/efs_out_if.sv @@
// Output channel of the field splitter: field characters and field-end marks.
// Depends on nothing but the handshake convention valid/ready.
interface efs_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  out_byte;
    logic [15:0] field_index;
    logic        pending_overflow;
    logic        last;

    modport source (output valid, output kind, output out_byte, output field_index,
                    output pending_overflow, output last, input ready);
    modport sink (input valid, input kind, input out_byte, input field_index,
                  input pending_overflow, input last, output ready);
endinterface

@@ hdl/efs_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; holds the pending whitespace of the current field.
module efs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/efs_queue.sv @@
// Short command queue between the front (classify) and back (emit) parts.
// Depends on efs_pkg for the command type and the queue depth.
module efs_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  efs_pkg::t_cmd i_push_cmd,
    input  logic         i_pop,
    output efs_pkg::t_cmd o_head,
    output logic         o_empty,
    output logic         o_full
);
    import efs_pkg::*;

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_CW-1:0] r_count;

    function automatic logic [QUEUE_AW-1:0] ptr_next(input logic [QUEUE_AW-1:0] p);
        return (p == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Storage of the queued commands.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));

endmodule

@@ hdl/efs_front.sv @@
// Front part: accepts string bytes, tracks field state and queues output work.
// Depends on efs_pkg and efs_in_if; writes the pending whitespace RAM.
module efs_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  efs_pkg::t_cfg   i_cfg,
    efs_in_if.sink          i_in,
    input  logic            i_q_full,
    input  logic            i_flush_done,
    output logic            o_push,
    output efs_pkg::t_cmd   o_cmd,
    output efs_pkg::t_ram_wr o_ram_wr
);
    import efs_pkg::*;

    logic               r_esc;
    logic               r_run;
    logic [15:0]        r_fields;
    logic               r_has_chars;
    logic               r_text_seen;
    logic [PEND_CW-1:0] r_pend_cnt;
    logic               r_ovf;
    logic               r_flush_busy;

    logic               n_esc;
    logic               n_run;
    logic [15:0]        n_fields;
    logic               n_has_chars;
    logic               n_text_seen;
    logic [PEND_CW-1:0] n_pend_cnt;
    logic               n_ovf;
    logic               n_flush_busy;

    logic               accept;
    logic               match;
    logic               room;
    logic [7:0]         c;
    logic [15:0]        fields_inc;

    // New bytes are taken while the queue has room and no flush reads the buffer.
    assign i_in.ready = !i_q_full && !r_flush_busy;
    assign accept     = i_in.valid && i_in.ready;
    assign c          = i_in.in_byte;
    assign match      = i_cfg.sep_is_whitespace ? is_ws(c) : (c == i_cfg.separator);
    assign room       = (i_cfg.max_fields == 16'd0) || (r_fields < i_cfg.max_fields);
    assign fields_inc = (r_fields != 16'hFFFF) ? r_fields + 16'd1 : r_fields;

    // Classification of the transaction and next field state.
    always_comb begin
        n_esc        = r_esc;
        n_run        = r_run;
        n_fields     = r_fields;
        n_has_chars  = r_has_chars;
        n_text_seen  = r_text_seen;
        n_pend_cnt   = r_pend_cnt;
        n_ovf        = r_ovf;
        n_flush_busy = r_flush_busy && !i_flush_done;
        o_push       = 1'b0;
        o_cmd.op          = OP_CHAR;
        o_cmd.char_byte   = c;
        o_cmd.field_index = r_fields;
        o_cmd.overflow    = r_ovf;
        o_cmd.pend_count  = r_pend_cnt;
        o_ram_wr.we   = 1'b0;
        o_ram_wr.addr = r_pend_cnt[PEND_AW-1:0];
        o_ram_wr.data = c;

        if (accept) begin
            if (i_in.end_of_string) begin
                // Close a non-empty field, then return to the start-of-string state.
                if (r_has_chars) begin
                    o_push          = 1'b1;
                    o_cmd.op        = OP_CLOSE;
                    o_cmd.char_byte = 8'd0;
                end
                n_esc       = 1'b0;
                n_run       = 1'b0;
                n_fields    = 16'd0;
                n_has_chars = 1'b0;
                n_text_seen = 1'b0;
                n_pend_cnt  = '0;
                n_ovf       = 1'b0;
            end else if (match && !r_esc && room) begin
                // Separator: close the field unless it continues a grouped run.
                if (!(i_cfg.group_separators && r_run)) begin
                    n_run           = i_cfg.group_separators;
                    o_push          = 1'b1;
                    o_cmd.op        = OP_CLOSE;
                    o_cmd.char_byte = 8'd0;
                    n_fields        = fields_inc;
                    n_has_chars     = 1'b0;
                    n_text_seen     = 1'b0;
                    n_pend_cnt      = '0;
                    n_ovf           = 1'b0;
                end
            end else begin
                n_run = 1'b0;
                if (!r_esc && (c == CHAR_BACKSLASH)) begin
                    // A backslash escapes the next byte and is dropped.
                    n_esc = 1'b1;
                end else begin
                    n_esc       = 1'b0;
                    n_has_chars = 1'b1;
                    if (!i_cfg.trim_fields) begin
                        o_push = 1'b1;
                    end else if (is_ws(c)) begin
                        // Whitespace after text waits in the buffer.
                        if (r_text_seen) begin
                            if (r_pend_cnt < PEND_CW'(PENDING_DEPTH)) begin
                                o_ram_wr.we = 1'b1;
                                n_pend_cnt  = r_pend_cnt + 1'b1;
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                    end else begin
                        // Text releases the held whitespace ahead of itself.
                        o_push      = 1'b1;
                        n_pend_cnt  = '0;
                        n_text_seen = 1'b1;
                        if (r_pend_cnt != '0) begin
                            o_cmd.op     = OP_FLUSH;
                            n_flush_busy = 1'b1;
                        end
                    end
                end
            end
        end
    end

    // Field state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc        <= 1'b0;
            r_run        <= 1'b0;
            r_fields     <= 16'd0;
            r_has_chars  <= 1'b0;
            r_text_seen  <= 1'b0;
            r_pend_cnt   <= '0;
            r_ovf        <= 1'b0;
            r_flush_busy <= 1'b0;
        end else begin
            r_esc        <= n_esc;
            r_run        <= n_run;
            r_fields     <= n_fields;
            r_has_chars  <= n_has_chars;
            r_text_seen  <= n_text_seen;
            r_pend_cnt   <= n_pend_cnt;
            r_ovf        <= n_ovf;
            r_flush_busy <= n_flush_busy;
        end
    end

endmodule

@@ hdl/efs_back.sv @@
// Back part: turns queued commands into output transactions, reading the
// pending whitespace RAM for flushes. Depends on efs_pkg and efs_out_if.
module efs_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  efs_pkg::t_cmd               i_head,
    input  logic                        i_empty,
    output logic                        o_pop,
    output logic                        o_flush_done,
    output logic [efs_pkg::PEND_AW-1:0] o_raddr,
    input  logic [7:0]                  i_rdata,
    efs_out_if.source                   o_out
);
    import efs_pkg::*;

    t_bk_state          r_state;
    t_bk_state          n_state;
    logic [PEND_CW-1:0] r_rd_idx;
    logic [PEND_CW-1:0] n_rd_idx;
    logic               r_rd_ok;
    logic               n_rd_ok;

    logic               r_out_valid;
    logic               r_out_kind;
    logic [7:0]         r_out_byte;
    logic [15:0]        r_out_fidx;
    logic               r_out_ovf;
    logic               r_out_last;

    logic               out_free;
    logic               load;
    logic               ld_kind;
    logic [7:0]         ld_byte;
    logic               ld_last;

    assign out_free = !r_out_valid || o_out.ready;
    assign o_raddr  = r_rd_idx[PEND_AW-1:0];

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_rd_idx <= '0;
            r_rd_ok  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_idx <= n_rd_idx;
            r_rd_ok  <= n_rd_ok;
        end
    end

    // Next state and output loading.
    always_comb begin
        n_state      = r_state;
        n_rd_idx     = r_rd_idx;
        n_rd_ok      = 1'b1;
        load         = 1'b0;
        ld_kind      = 1'b0;
        ld_byte      = i_head.char_byte;
        ld_last      = 1'b1;
        o_pop        = 1'b0;
        o_flush_done = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_empty && out_free) begin
                    if (i_head.op == OP_FLUSH) begin
                        n_state  = BK_FLUSH;
                        n_rd_idx = '0;
                        n_rd_ok  = 1'b0;
                    end else begin
                        load    = 1'b1;
                        ld_kind = (i_head.op == OP_CLOSE);
                        o_pop   = 1'b1;
                    end
                end
            end
            BK_FLUSH: begin
                if (r_rd_idx == i_head.pend_count) begin
                    // All whitespace sent; the text byte ends the transaction group.
                    if (out_free) begin
                        load         = 1'b1;
                        o_pop        = 1'b1;
                        o_flush_done = 1'b1;
                        n_state      = BK_IDLE;
                    end
                end else if (r_rd_ok && out_free) begin
                    // Read data matches the current address: send it and step on.
                    load     = 1'b1;
                    ld_byte  = i_rdata;
                    ld_last  = 1'b0;
                    n_rd_idx = r_rd_idx + 1'b1;
                    n_rd_ok  = 1'b0;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_kind <= ld_kind;
            r_out_byte <= ld_byte;
            r_out_fidx <= i_head.field_index;
            r_out_ovf  <= i_head.overflow;
            r_out_last <= ld_last;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.kind             = r_out_kind;
    assign o_out.out_byte         = r_out_byte;
    assign o_out.field_index      = r_out_fidx;
    assign o_out.pending_overflow = r_out_ovf;
    assign o_out.last             = r_out_last;

endmodule

@@ hdl/escaped_field_splitter_top.sv @@
// A field character or end mark goes through the command queue and the output register.
// Throughput: one byte per cycle while each byte yields at most one transaction and the
// receiver is ready. A byte that releases held whitespace starts a flush that sends each
// held byte via the registered RAM read, then the text byte; input stalls meanwhile.
// Reset: synchronous, active low; clears field state, queue, output and configuration.
// The whitespace RAM is not cleared; only entries written in the current field are read.
module escaped_field_splitter_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    efs_in_if.sink                      i_in,
    efs_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [efs_pkg::CFG_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import efs_pkg::*;

    t_cfg               r_cfg;
    logic               cfg_wr;
    logic [2:0]         reg_idx;

    logic               q_push;
    t_cmd               q_push_cmd;
    logic               q_pop;
    t_cmd               q_head;
    logic               q_empty;
    logic               q_full;
    logic               flush_done;
    t_ram_wr            ram_wr;
    logic [PEND_AW-1:0] ram_raddr;
    logic [7:0]         ram_rdata;

    // Configuration port: writes land in the access cycle.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.separator         <= SEPARATOR_RESET;
            r_cfg.sep_is_whitespace <= 1'b0;
            r_cfg.max_fields        <= 16'd0;
            r_cfg.group_separators  <= 1'b0;
            r_cfg.trim_fields       <= 1'b0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_SEPARATOR:   r_cfg.separator         <= pwdata[7:0];
                REG_SEP_IS_WS:   r_cfg.sep_is_whitespace <= pwdata[0];
                REG_MAX_FIELDS:  r_cfg.max_fields        <= pwdata[15:0];
                REG_GROUP_SEPS:  r_cfg.group_separators  <= pwdata[0];
                REG_TRIM_FIELDS: r_cfg.trim_fields       <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (reg_idx)
            REG_SEPARATOR:   prdata = {24'd0, r_cfg.separator};
            REG_SEP_IS_WS:   prdata = {31'd0, r_cfg.sep_is_whitespace};
            REG_MAX_FIELDS:  prdata = {16'd0, r_cfg.max_fields};
            REG_GROUP_SEPS:  prdata = {31'd0, r_cfg.group_separators};
            REG_TRIM_FIELDS: prdata = {31'd0, r_cfg.trim_fields};
            default:         prdata = 32'd0;
        endcase
    end

    efs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in         (i_in),
        .i_q_full     (q_full),
        .i_flush_done (flush_done),
        .o_push       (q_push),
        .o_cmd        (q_push_cmd),
        .o_ram_wr     (ram_wr)
    );

    efs_ram #(
        .WIDTH (8),
        .DEPTH (PENDING_DEPTH)
    ) u_pend_ram (
        .i_clk   (i_clk),
        .i_we    (ram_wr.we),
        .i_waddr (ram_wr.addr),
        .i_wdata (ram_wr.data),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    efs_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_cmd (q_push_cmd),
        .i_pop      (q_pop),
        .o_head     (q_head),
        .o_empty    (q_empty),
        .o_full     (q_full)
    );

    efs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (q_head),
        .i_empty      (q_empty),
        .o_pop        (q_pop),
        .o_flush_done (flush_done),
        .o_raddr      (ram_raddr),
        .i_rdata      (ram_rdata),
        .o_out        (o_out)
    );

`ifndef NO_ASSERTIONS
    // The front part never queues work into a full queue.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("command queued while queue full");

    // The back part never pops an empty queue.
    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("command popped from empty queue");

    // A field-end mark carries a zero byte and always ends its group of transactions.
    a_mark_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind) |-> (o_out.last && (o_out.out_byte == 8'd0)))
        else $error("malformed field-end mark");

    // The output holds no transaction in the cycle after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");
`endif

endmodule

@@ tb/escaped_field_splitter_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for escaped_field_splitter_top: directed and random strings.
// Depends on efs_pkg, efs_in_if, efs_out_if and the block itself.
module escaped_field_splitter_top_tb;
    import efs_pkg::*;

    // Kinds of output transaction.
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END = 1'b1;

    // Register index that no register uses; writes there must change nothing.
    localparam logic [2:0] REG_UNUSED = 3'd7;

    // Cycles to wait after the last expected result, enough for a full flush.
    localparam int TAIL_CYCLES = 2 * PENDING_DEPTH + 8;

    // Cycles without any transaction before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 4000;

    // At most this many mismatches are printed in full.
    localparam int PRINT_LIMIT = 20;

    typedef struct packed {
        logic        kind;
        logic [7:0]  out_byte;
        logic [15:0] field_index;
        logic        pending_overflow;
        logic        last;
    } t_field_result;

    // Tracks the splitter state, predicts field results and checks them in order.
    class field_split_scoreboard;
        logic [7:0]     separator = SEPARATOR_RESET;
        logic           blank_sep = 1'b0;
        logic [15:0]    field_limit = 16'd0;
        logic           merge_runs = 1'b0;
        logic           trim_blanks = 1'b0;

        logic           escape_armed = 1'b0;
        logic           in_run = 1'b0;
        int             closed_count = 0;
        logic           field_nonempty = 1'b0;
        logic           text_started = 1'b0;
        logic [7:0]     held_ws [PENDING_DEPTH];
        int             held_count = 0;
        logic           held_dropped = 1'b0;

        t_field_result  fields_due [$];
        t_field_result  burst [$];
        int             mismatches = 0;
        int             results_checked = 0;

        function automatic logic is_blank(input logic [7:0] c);
            return (c == CHAR_SPACE) || (c == CHAR_TAB);
        endfunction

        function void set_config(input logic [2:0] idx, input logic [31:0] value);
            case (idx)
                REG_SEPARATOR: separator = value[7:0];
                REG_SEP_IS_WS: blank_sep = value[0];
                REG_MAX_FIELDS: field_limit = value[15:0];
                REG_GROUP_SEPS: merge_runs = value[0];
                REG_TRIM_FIELDS: trim_blanks = value[0];
                default: ;
            endcase
        endfunction

        function void emit(input logic kind, input logic [7:0] b);
            burst.push_back('{kind, b, closed_count[15:0], held_dropped, 1'b0});
        endfunction

        function void clear_field();
            field_nonempty = 1'b0;
            text_started = 1'b0;
            held_count = 0;
            held_dropped = 1'b0;
        endfunction

        function void close_field();
            emit(KIND_END, 8'h00);
            if (closed_count < 65535) closed_count++;
            clear_field();
        endfunction

        // Works out the field results caused by one accepted transaction.
        function void split_byte(input logic [7:0] c, input logic eos);
            logic is_sep;
            logic room;
            logic swallowed;
            swallowed = 1'b0;
            burst.delete();
            if (eos) begin
                if (field_nonempty) close_field();
                escape_armed = 1'b0;
                in_run = 1'b0;
                closed_count = 0;
                clear_field();
            end else begin
                is_sep = blank_sep ? is_blank(c) : (c == separator);
                room = (field_limit == 0) || (closed_count < field_limit);
                if (is_sep && !escape_armed && room) begin
                    // A separator inside a merged run closes nothing.
                    if (!(merge_runs && in_run)) begin
                        in_run = merge_runs;
                        close_field();
                    end
                end else begin
                    in_run = 1'b0;
                    if (escape_armed) begin
                        escape_armed = 1'b0;
                    end else if (c == CHAR_BACKSLASH) begin
                        escape_armed = 1'b1;
                        swallowed = 1'b1;
                    end
                    if (!swallowed) begin
                        field_nonempty = 1'b1;
                        if (!trim_blanks) begin
                            emit(KIND_CHAR, c);
                        end else if (is_blank(c)) begin
                            // Whitespace after text is held until more text follows.
                            if (text_started) begin
                                if (held_count < PENDING_DEPTH) begin
                                    held_ws[held_count[PEND_AW-1:0]] = c;
                                    held_count++;
                                end else begin
                                    held_dropped = 1'b1;
                                end
                            end
                        end else begin
                            for (int i = 0; i < held_count; i++)
                                emit(KIND_CHAR, held_ws[i[PEND_AW-1:0]]);
                            held_count = 0;
                            emit(KIND_CHAR, c);
                            text_started = 1'b1;
                        end
                    end
                end
            end
            if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
            foreach (burst[i]) fields_due.push_back(burst[i]);
        endfunction

        // Compares one accepted output transaction with the oldest expectation.
        function void check_field_result(input t_field_result got);
            t_field_result want;
            results_checked++;
            if (fields_due.size() == 0) begin
                mismatches++;
                if (mismatches <= PRINT_LIMIT)
                    $display("%0t: unexpected result, expected none, got kind=%0d byte=%02h index=%0d ovf=%0d last=%0d",
                             $time, got.kind, got.out_byte, got.field_index,
                             got.pending_overflow, got.last);
                return;
            end
            want = fields_due.pop_front();
            if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
                got.field_index !== want.field_index ||
                got.pending_overflow !== want.pending_overflow || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= PRINT_LIMIT) begin
                    $display("%0t: result mismatch, expected kind=%0d byte=%02h index=%0d ovf=%0d last=%0d",
                             $time, want.kind, want.out_byte, want.field_index,
                             want.pending_overflow, want.last);
                    $display("%0t:                   actual kind=%0d byte=%02h index=%0d ovf=%0d last=%0d",
                             $time, got.kind, got.out_byte, got.field_index,
                             got.pending_overflow, got.last);
                end
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    efs_in_if  in_ch ();
    efs_out_if out_ch ();

    field_split_scoreboard splitter_model;

    int gap_pct = 0;
    int stall_pct = 0;
    int items_sent = 0;
    int reg_writes = 0;
    int quiet_cycles = 0;

    escaped_field_splitter_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Free-running clock, 2 ns period.
    always begin
        #1 i_clk = 1'b0;
        #1 i_clk = 1'b1;
    end

    // Receiver back-pressure.
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Output monitor: every accepted transaction goes to the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            splitter_model.check_field_result(t_field_result'{out_ch.kind, out_ch.out_byte,
                out_ch.field_index, out_ch.pending_overflow, out_ch.last});
        end
    end

    // Watchdog on cycles in which nothing moves.
    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, run abandoned", $time, quiet_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Offers one transaction, with random idle cycles first, and waits for its acceptance.
    task automatic send_byte(input logic [7:0] b, input logic eos);
        while ($urandom_range(99) < gap_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.end_of_string <= eos;
        do @(posedge i_clk); while (!in_ch.ready);
        splitter_model.split_byte(b, eos);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
    endtask

    task automatic end_string();
        send_byte(8'($urandom_range(255)), 1'b1);
    endtask

    // Stops offering input and waits until every expected result has arrived.
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (splitter_model.fields_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        splitter_model.set_config(idx, value);
        reg_writes++;
        @(posedge i_clk);
    endtask

    task automatic apply_setup(input logic [7:0] sep, input logic ws, input logic [15:0] lim,
                               input logic grp, input logic trim);
        settle();
        write_reg(REG_SEPARATOR, {24'd0, sep});
        write_reg(REG_SEP_IS_WS, {31'd0, ws});
        write_reg(REG_MAX_FIELDS, {16'd0, lim});
        write_reg(REG_GROUP_SEPS, {31'd0, grp});
        write_reg(REG_TRIM_FIELDS, {31'd0, trim});
    endtask

    // Random setting; the first two of a run are the extremes.
    task automatic change_setup(input int k);
        logic [7:0]  sep;
        logic [15:0] lim;
        if (k == 0) begin
            apply_setup(8'h00, 1'b0, 16'hFFFF, 1'b1, 1'b1);
        end else if (k == 1) begin
            apply_setup(8'hFF, 1'b1, 16'd1, 1'b0, 1'b0);
        end else begin
            case ($urandom_range(5))
                0: sep = ",";
                1: sep = CHAR_SPACE;
                2: sep = CHAR_BACKSLASH;
                3: sep = 8'h00;
                4: sep = 8'hFF;
                default: sep = 8'($urandom_range(255));
            endcase
            case ($urandom_range(5))
                0, 1: lim = 16'd0;
                2: lim = 16'd1;
                3: lim = 16'd2;
                4: lim = 16'hFFFF;
                default: lim = 16'($urandom_range(8, 3));
            endcase
            apply_setup(sep, 1'($urandom_range(1)), lim, 1'($urandom_range(1)),
                        1'($urandom_range(1)));
        end
    endtask

    function automatic logic [7:0] pick_blank();
        return $urandom_range(1) ? CHAR_SPACE : CHAR_TAB;
    endfunction

    // Mostly well-formed strings of words, separators, escapes and whitespace; some noise.
    task automatic send_random_string();
        int          len;
        logic        noise;
        logic [7:0]  c;
        noise = ($urandom_range(4) == 0);
        len = $urandom_range(20, 1);
        for (int i = 0; i < len; i++) begin
            if (noise) begin
                c = 8'($urandom_range(255));
            end else begin
                case ($urandom_range(15))
                    0, 1, 2: c = splitter_model.blank_sep ? pick_blank() : splitter_model.separator;
                    3: c = CHAR_BACKSLASH;
                    4, 5: c = pick_blank();
                    6: c = 8'($urandom_range(255));
                    7: begin
                        // A long whitespace run, at times long enough to overflow the held buffer.
                        repeat ($urandom_range(20, 10)) send_byte(pick_blank(), 1'b0);
                        c = "q";
                    end
                    default: c = 8'("a" + $urandom_range(25));
                endcase
            end
            send_byte(c, 1'b0);
        end
        // A string left open lets the next setting take effect mid-string.
        if (noise ? ($urandom_range(1) == 1) : ($urandom_range(9) != 0)) end_string();
    endtask

    initial begin : stimulus
        int setting;
        int mode_goal;
        splitter_model = new();
        i_rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.in_byte <= 8'h00;
        in_ch.end_of_string <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= 32'd0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: plain text, escaped separator and backslash, extreme bytes, empty strings.
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        send_text("a,\\,");
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_text("\\\\");
        end_string();
        end_string();
        send_byte(CHAR_BACKSLASH, 1'b0);
        end_string();

        // Directed: trimming with a trailing whitespace run that overflows the buffer.
        settle();
        write_reg(REG_TRIM_FIELDS, 32'd1);
        send_byte(CHAR_SPACE, 1'b0);
        send_text("x");
        for (int i = 0; i <= PENDING_DEPTH; i++) send_byte(i[0] ? CHAR_TAB : CHAR_SPACE, 1'b0);
        send_text("y");
        end_string();

        // Random strings under three idling patterns, with frequent setting changes.
        setting = 0;
        for (int mode = 0; mode < 3; mode++) begin
            gap_pct = (mode == 0) ? 22 : (mode == 1) ? 47 : 0;
            stall_pct = (mode == 0) ? 47 : (mode == 1) ? 22 : 0;
            mode_goal = items_sent + 90;
            while (items_sent < mode_goal) begin
                change_setup(setting);
                setting++;
                repeat ($urandom_range(3, 1)) send_random_string();
            end
        end

        settle();
        $display("Covered %0d input transactions and %0d field results over %0d register writes,",
                 items_sent, splitter_model.results_checked, reg_writes);
        $display("with escapes, trimming, buffer overflow, merged runs and field limits.");
        if (splitter_model.fields_due.size() != 0)
            $display("%0t: %0d expected results never arrived", $time,
                     splitter_model.fields_due.size());
        if (splitter_model.mismatches == 0 && splitter_model.fields_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

@@ sim.f @@
hdl/efs_pkg.sv
hdl/efs_in_if.sv
hdl/efs_out_if.sv
hdl/efs_ram.sv
hdl/efs_queue.sv
hdl/efs_front.sv
hdl/efs_back.sv
hdl/escaped_field_splitter_top.sv
tb/escaped_field_splitter_top_tb.sv
